FILE: design/ngh_pkg.sv
package ngh_pkg;

  // Default widths of the sample and coefficient formats
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int COEF_BITS_DEF   = 16;

  // Fixed widths of the hold counter and the register index
  localparam int HOLD_BITS    = 18;
  localparam int CFG_IDX_BITS = 3;

  // Register values after reset
  localparam int RST_ATTACK_COEF  = 1359;
  localparam int RST_RELEASE_COEF = 17;
  localparam int RST_OPEN_LEVEL   = 66592;
  localparam int RST_CLOSE_LEVEL  = 47144;
  localparam int RST_HOLD_SAMPLES = 1920;
  localparam int RST_FLOOR_GAIN   = 7;
  localparam int RST_DET_SOURCE   = 0;
  localparam int RST_STEREO       = 1;

  // Detector source codes; any other code selects the main channels
  localparam logic [1:0] DET_SIDE_L  = 2'd1;
  localparam logic [1:0] DET_SIDE_LR = 2'd2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ATTACK_COEF  = 3'd0,
    CFG_RELEASE_COEF = 3'd1,
    CFG_OPEN_LEVEL   = 3'd2,
    CFG_CLOSE_LEVEL  = 3'd3,
    CFG_HOLD_SAMPLES = 3'd4,
    CFG_FLOOR_GAIN   = 3'd5,
    CFG_DET_SOURCE   = 3'd6,
    CFG_STEREO       = 3'd7
  } cfg_idx_t;

  // Operand selection of the shared multiplier
  typedef enum logic [2:0] {
    MUL_NONE  = 3'd0,
    MUL_ENV   = 3'd1,
    MUL_GAIN  = 3'd2,
    MUL_LEFT  = 3'd3,
    MUL_RIGHT = 3'd4
  } mul_op_t;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic    load_in;
    mul_op_t mul_op;
    logic    upd_diff;
    logic    upd_env;
    logic    upd_gain;
    logic    cap_left;
    logic    load_out;
  } dp_cmd_t;

endpackage

FILE: design/ngh_cfg.sv
module ngh_cfg #(
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_BITS   = 16,
  parameter int CFG_DW      = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  ngh_pkg::cfg_idx_t             cfg_index,
  input  logic [CFG_DW-1:0]             cfg_data,
  output logic [COEF_BITS-1:0]          attack_coef,
  output logic [COEF_BITS-1:0]          release_coef,
  output logic [SAMPLE_BITS-1:0]        open_level,
  output logic [SAMPLE_BITS-1:0]        close_level,
  output logic [ngh_pkg::HOLD_BITS-1:0] hold_samples,
  output logic [COEF_BITS:0]            floor_gain,
  output logic [1:0]                    detector_source,
  output logic                          stereo
);
  import ngh_pkg::*;

  logic [COEF_BITS-1:0]   attack_r;
  logic [COEF_BITS-1:0]   release_r;
  logic [SAMPLE_BITS-1:0] open_r;
  logic [SAMPLE_BITS-1:0] close_r;
  logic [HOLD_BITS-1:0]   hold_r;
  logic [COEF_BITS:0]     floor_r;
  logic [1:0]             det_src_r;
  logic                   stereo_r;

  // Register file: one register written per completed transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r  <= COEF_BITS'(RST_ATTACK_COEF);
      release_r <= COEF_BITS'(RST_RELEASE_COEF);
      open_r    <= SAMPLE_BITS'(RST_OPEN_LEVEL);
      close_r   <= SAMPLE_BITS'(RST_CLOSE_LEVEL);
      hold_r    <= HOLD_BITS'(RST_HOLD_SAMPLES);
      floor_r   <= (COEF_BITS + 1)'(RST_FLOOR_GAIN);
      det_src_r <= 2'(RST_DET_SOURCE);
      stereo_r  <= 1'(RST_STEREO);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ATTACK_COEF:  attack_r  <= cfg_data[COEF_BITS-1:0];
        CFG_RELEASE_COEF: release_r <= cfg_data[COEF_BITS-1:0];
        CFG_OPEN_LEVEL:   open_r    <= cfg_data[SAMPLE_BITS-1:0];
        CFG_CLOSE_LEVEL:  close_r   <= cfg_data[SAMPLE_BITS-1:0];
        CFG_HOLD_SAMPLES: hold_r    <= cfg_data[HOLD_BITS-1:0];
        CFG_FLOOR_GAIN:   floor_r   <= cfg_data[COEF_BITS:0];
        CFG_DET_SOURCE:   det_src_r <= cfg_data[1:0];
        CFG_STEREO:       stereo_r  <= cfg_data[0];
      endcase
    end
  end

  assign attack_coef     = attack_r;
  assign release_coef    = release_r;
  assign open_level      = open_r;
  assign close_level     = close_r;
  assign hold_samples    = hold_r;
  assign floor_gain      = floor_r;
  assign detector_source = det_src_r;
  assign stereo          = stereo_r;

endmodule

FILE: design/ngh_ctrl.sv
module ngh_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  output ngh_pkg::dp_cmd_t cmd
);
  import ngh_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_ENV_MUL,
    S_ENV_UPD,
    S_GAIN_MUL,
    S_GAIN_UPD,
    S_LEFT_MUL,
    S_RIGHT_MUL,
    S_FINISH
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;

  // The output register can take a new result when empty or being emptied
  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  // Command decode for each step of the sequence
  always_comb begin
    cmd        = '0;
    cmd.mul_op = MUL_NONE;
    unique case (state_r)
      S_IDLE:      cmd.load_in  = in_tvalid;
      S_DIFF:      cmd.upd_diff = 1'b1;
      S_ENV_MUL:   cmd.mul_op   = MUL_ENV;
      S_ENV_UPD:   cmd.upd_env  = 1'b1;
      S_GAIN_MUL:  cmd.mul_op   = MUL_GAIN;
      S_GAIN_UPD:  cmd.upd_gain = 1'b1;
      S_LEFT_MUL:  cmd.mul_op   = MUL_LEFT;
      S_RIGHT_MUL: begin
        cmd.mul_op   = MUL_RIGHT;
        cmd.cap_left = 1'b1;
      end
      S_FINISH:    cmd.load_out = out_free;
      default:     cmd.mul_op   = MUL_NONE;
    endcase
  end

  // Sequencer state and the output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE:      if (in_tvalid) state_r <= S_DIFF;
        S_DIFF:      state_r <= S_ENV_MUL;
        S_ENV_MUL:   state_r <= S_ENV_UPD;
        S_ENV_UPD:   state_r <= S_GAIN_MUL;
        S_GAIN_MUL:  state_r <= S_GAIN_UPD;
        S_GAIN_UPD:  state_r <= S_LEFT_MUL;
        S_LEFT_MUL:  state_r <= S_RIGHT_MUL;
        S_RIGHT_MUL: state_r <= S_FINISH;
        S_FINISH:    if (out_free) state_r <= S_IDLE;
        default:     state_r <= S_IDLE;
      endcase
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  // An accepted frame starts the sequence on the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == S_DIFF)
    else $error("accepted frame did not start the sequence");

  // A new result appears only from the final step
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FINISH && state_r == S_IDLE)
    else $error("result raised outside the final step");

  // No second frame is taken while one is being worked on
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_in |=> !in_tready)
    else $error("input ready while busy");
`endif

endmodule

FILE: design/ngh_dp.sv
module ngh_dp #(
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ngh_pkg::dp_cmd_t              cmd,
  input  logic signed [SAMPLE_BITS-1:0] in_left,
  input  logic signed [SAMPLE_BITS-1:0] in_right,
  input  logic signed [SAMPLE_BITS-1:0] side_left,
  input  logic signed [SAMPLE_BITS-1:0] side_right,
  input  logic [COEF_BITS-1:0]          attack_coef,
  input  logic [COEF_BITS-1:0]          release_coef,
  input  logic [SAMPLE_BITS-1:0]        open_level,
  input  logic [SAMPLE_BITS-1:0]        close_level,
  input  logic [ngh_pkg::HOLD_BITS-1:0] hold_samples,
  input  logic [COEF_BITS:0]            floor_gain,
  input  logic [1:0]                    detector_source,
  input  logic                          stereo,
  output logic signed [SAMPLE_BITS-1:0] out_left,
  output logic signed [SAMPLE_BITS-1:0] out_right,
  output logic [COEF_BITS:0]            gain_now,
  output logic                          gate_open
);
  import ngh_pkg::*;

  // Multiplier operand and product widths
  localparam int MA = (SAMPLE_BITS + 1 > COEF_BITS + 2) ? SAMPLE_BITS + 1 : COEF_BITS + 2;
  localparam int PW = MA + COEF_BITS + 2;
  localparam logic [COEF_BITS:0]     UNITY    = {1'b1, {COEF_BITS{1'b0}}};
  localparam logic [SAMPLE_BITS-1:0] ENV_MAX  = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  function automatic logic [SAMPLE_BITS-1:0] mag(input logic signed [SAMPLE_BITS-1:0] v);
    logic signed [SAMPLE_BITS:0] w;
    w = {v[SAMPLE_BITS-1], v};
    if (w[SAMPLE_BITS]) w = -w;
    return w[SAMPLE_BITS-1:0];
  endfunction

  logic signed [SAMPLE_BITS-1:0] left_r;
  logic signed [SAMPLE_BITS-1:0] right_r;
  logic [SAMPLE_BITS-1:0]        det_r;
  logic signed [SAMPLE_BITS:0]   diff_r;
  logic                          rising_r;
  logic [SAMPLE_BITS-1:0]        env_r;
  logic [COEF_BITS:0]            gain_r;
  logic [HOLD_BITS-1:0]          hold_r;
  logic                          open_r;
  logic signed [PW-1:0]          prod_r;
  logic signed [SAMPLE_BITS-1:0] left_out_r;
  logic signed [SAMPLE_BITS-1:0] out_left_r;
  logic signed [SAMPLE_BITS-1:0] out_right_r;
  logic [COEF_BITS:0]            out_gain_r;
  logic                          out_open_r;

  logic [SAMPLE_BITS-1:0]        mag_l, mag_r, mag_sl, mag_sr, det;
  logic signed [SAMPLE_BITS:0]   diff;
  logic [COEF_BITS:0]            floor_lim, gain_tgt;
  logic signed [COEF_BITS+1:0]   gain_diff;
  logic signed [MA-1:0]          mul_a;
  logic [COEF_BITS:0]            mul_b;
  logic signed [PW-1:0]          prod;
  logic signed [SAMPLE_BITS+1:0] env_sum;
  logic [SAMPLE_BITS-1:0]        env_new;
  logic                          open_nxt;
  logic [HOLD_BITS-1:0]          hold_nxt;
  logic signed [COEF_BITS+2:0]   gain_sum;
  logic [COEF_BITS:0]            gain_nxt;
  logic signed [SAMPLE_BITS:0]   prod_sh;
  logic signed [SAMPLE_BITS-1:0] sat;

  // Peak detector over the selected channels, taken from the input transfer
  assign mag_l  = mag(in_left);
  assign mag_r  = stereo ? mag(in_right) : '0;
  assign mag_sl = mag(side_left);
  assign mag_sr = mag(side_right);

  always_comb begin
    unique case (detector_source)
      DET_SIDE_L:  det = mag_sl;
      DET_SIDE_LR: det = (mag_sr > mag_sl) ? mag_sr : mag_sl;
      default:     det = (mag_r > mag_l) ? mag_r : mag_l;
    endcase
  end

  // Distance from the envelope to the detector
  assign diff = $signed({1'b0, det_r}) - $signed({1'b0, env_r});

  // Gain target: unity while open, else the floor limited to unity
  assign floor_lim = (floor_gain > UNITY) ? UNITY : floor_gain;
  assign gain_tgt  = open_r ? UNITY : floor_lim;
  assign gain_diff = $signed({1'b0, gain_tgt}) - $signed({1'b0, gain_r});

  // Shared multiplier operand selection
  always_comb begin
    unique case (cmd.mul_op)
      MUL_ENV: begin
        mul_a = MA'(diff_r);
        mul_b = {1'b0, rising_r ? attack_coef : release_coef};
      end
      MUL_GAIN: begin
        mul_a = MA'(gain_diff);
        mul_b = {1'b0, open_r ? attack_coef : release_coef};
      end
      MUL_LEFT: begin
        mul_a = MA'(left_r);
        mul_b = gain_r;
      end
      MUL_RIGHT: begin
        mul_a = MA'(right_r);
        mul_b = gain_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * $signed({1'b0, mul_b});

  // Envelope step, floor of the scaled product
  assign env_sum = $signed({2'b00, env_r}) + prod_r[COEF_BITS +: SAMPLE_BITS + 2];
  assign env_new = env_sum[SAMPLE_BITS-1:0];

  // Gate decision with hold and hysteresis on the new envelope
  always_comb begin
    open_nxt = open_r;
    hold_nxt = hold_r;
    priority if (env_new >= open_level) begin
      open_nxt = 1'b1;
      hold_nxt = hold_samples;
    end else if (open_r && hold_r != '0) begin
      hold_nxt = hold_r - 1'b1;
    end else if (env_new <= close_level) begin
      open_nxt = 1'b0;
    end
  end

  // Gain glide, clamped to zero..unity
  assign gain_sum = $signed({2'b00, gain_r}) + prod_r[COEF_BITS +: COEF_BITS + 3];

  always_comb begin
    priority if (gain_sum < 0) begin
      gain_nxt = '0;
    end else if (gain_sum > $signed({2'b00, UNITY})) begin
      gain_nxt = UNITY;
    end else begin
      gain_nxt = gain_sum[COEF_BITS:0];
    end
  end

  // Sample times gain, saturated to the sample range
  assign prod_sh = prod_r[COEF_BITS +: SAMPLE_BITS + 1];
  assign sat = (prod_sh[SAMPLE_BITS] != prod_sh[SAMPLE_BITS-1]) ?
               {prod_sh[SAMPLE_BITS], {(SAMPLE_BITS - 1){~prod_sh[SAMPLE_BITS]}}} :
               prod_sh[SAMPLE_BITS-1:0];

  // Filter and gate state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      env_r  <= '0;
      gain_r <= '0;
      hold_r <= '0;
      open_r <= 1'b0;
    end else begin
      if (cmd.upd_env) begin
        env_r  <= env_new;
        open_r <= open_nxt;
        hold_r <= hold_nxt;
      end
      if (cmd.upd_gain) begin
        gain_r <= gain_nxt;
      end
    end
  end

  // Working registers and the output register
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      left_r  <= in_left;
      right_r <= in_right;
      det_r   <= det;
    end
    if (cmd.upd_diff) begin
      diff_r   <= diff;
      rising_r <= !diff[SAMPLE_BITS] && (diff != '0);
    end
    if (cmd.mul_op != MUL_NONE) begin
      prod_r <= prod;
    end
    if (cmd.cap_left) begin
      left_out_r <= sat;
    end
    if (cmd.load_out) begin
      out_left_r  <= left_out_r;
      out_right_r <= stereo ? sat : '0;
      out_gain_r  <= gain_r;
      out_open_r  <= open_r;
    end
  end

  assign out_left  = out_left_r;
  assign out_right = out_right_r;
  assign gain_now  = out_gain_r;
  assign gate_open = out_open_r;

`ifndef SYNTHESIS
  // The glide never leaves zero..unity
  assert property (@(posedge clk) disable iff (!rst_n) gain_r <= UNITY)
    else $error("gain above unity");

  // The envelope stays within the detector range
  assert property (@(posedge clk) disable iff (!rst_n) env_r <= ENV_MAX)
    else $error("envelope out of range");

  // Reaching the open level opens the gate and reloads the hold count
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd_env && env_new >= open_level |=> open_r && hold_r == $past(hold_samples))
    else $error("gate did not open at the open level");
`endif

endmodule

FILE: design/noise_gate_hysteresis_hold.sv
// Noise gate with hold and hysteresis.
// Input channel in_*: one transfer carries a stereo frame and two sidechain
// samples, all signed Q1.23. Result channel out_*: one transfer per frame
// with both gated samples, the gain applied (Q1.16) and the gate state.
// Configuration channel cfg_*: register index and data; cfg_ready is always
// high and writes are meant to happen while no frame is in progress.
// Each frame passes a sequencer that uses one shared multiplier four times
// (envelope step, gain step, left and right product) with an update step
// after each filter product. A frame is accepted in the idle step and its
// result enters the output register in the final step; the next frame is
// taken once back in idle. The output register lets the next frame be accepted
// while a result still waits; if the receiver stalls, the sequence waits in
// its final step until the register is free, and input ready stays low.
// Reset (rst_n low at a clock edge) closes the gate, clears envelope, gain
// and hold count, empties the output register and loads the register
// defaults.
module noise_gate_hysteresis_hold #(
  parameter int  SAMPLE_BITS = ngh_pkg::SAMPLE_BITS_DEF,
  parameter int  COEF_BITS   = ngh_pkg::COEF_BITS_DEF,
  localparam int IN_W   = ((4 * SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W  = ((2 * SAMPLE_BITS + COEF_BITS + 2 + 7) / 8) * 8,
  localparam int CFG_DW = (SAMPLE_BITS > COEF_BITS + 1) ?
                          ((SAMPLE_BITS > ngh_pkg::HOLD_BITS) ? SAMPLE_BITS
                                                              : ngh_pkg::HOLD_BITS) :
                          ((COEF_BITS + 1 > ngh_pkg::HOLD_BITS) ? COEF_BITS + 1
                                                                : ngh_pkg::HOLD_BITS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // in_left, in_right, side_left, side_right
  input  logic [IN_W-1:0]   in_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  // out_left, out_right, gain_now, gate_open
  output logic [OUT_W-1:0]  out_tdata,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  ngh_pkg::cfg_idx_t cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);
  import ngh_pkg::*;

  dp_cmd_t                       cmd;
  logic [COEF_BITS-1:0]          attack_coef, release_coef;
  logic [SAMPLE_BITS-1:0]        open_level, close_level;
  logic [HOLD_BITS-1:0]          hold_samples;
  logic [COEF_BITS:0]            floor_gain;
  logic [1:0]                    detector_source;
  logic                          stereo;
  logic signed [SAMPLE_BITS-1:0] out_left, out_right;
  logic [COEF_BITS:0]            gain_now;
  logic                          gate_open;

  // Registers take a write on every cycle
  assign cfg_ready = 1'b1;

  ngh_cfg #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS),
    .CFG_DW      (CFG_DW)
  ) u_cfg (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .attack_coef     (attack_coef),
    .release_coef    (release_coef),
    .open_level      (open_level),
    .close_level     (close_level),
    .hold_samples    (hold_samples),
    .floor_gain      (floor_gain),
    .detector_source (detector_source),
    .stereo          (stereo)
  );

  ngh_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  ngh_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_left         (in_tdata[0 +: SAMPLE_BITS]),
    .in_right        (in_tdata[SAMPLE_BITS +: SAMPLE_BITS]),
    .side_left       (in_tdata[2 * SAMPLE_BITS +: SAMPLE_BITS]),
    .side_right      (in_tdata[3 * SAMPLE_BITS +: SAMPLE_BITS]),
    .attack_coef     (attack_coef),
    .release_coef    (release_coef),
    .open_level      (open_level),
    .close_level     (close_level),
    .hold_samples    (hold_samples),
    .floor_gain      (floor_gain),
    .detector_source (detector_source),
    .stereo          (stereo),
    .out_left        (out_left),
    .out_right       (out_right),
    .gain_now        (gain_now),
    .gate_open       (gate_open)
  );

  // Result fields packed from the lowest bit up, zero filled to whole bytes
  assign out_tdata = OUT_W'({gate_open, gain_now, out_right, out_left});

endmodule

FILE: verif/ngh_gate_checker.sv
`timescale 1ns / 100ps

module ngh_gate_checker
  import ngh_pkg::*;
#(
  parameter int IN_W   = 96,
  parameter int OUT_W  = 72,
  parameter int CFG_DW = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  // in_left, in_right, side_left, side_right
  input  logic [IN_W-1:0]   in_tdata,
  input  logic              out_tvalid,
  input  logic              out_tready,
  // out_left, out_right, gain_now, gate_open
  input  logic [OUT_W-1:0]  out_tdata,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  cfg_idx_t          cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  output int                mismatches,
  output int                frames_due,
  output int                frames_checked
);

  localparam int     SB         = SAMPLE_BITS_DEF;
  localparam int     CB         = COEF_BITS_DEF;
  localparam longint UNITY      = longint'(1) << CB;
  localparam longint SAMPLE_MAX = (longint'(1) << (SB - 1)) - 1;
  localparam longint SAMPLE_MIN = -(longint'(1) << (SB - 1));

  typedef struct {
    logic [SB-1:0] left;
    logic [SB-1:0] right;
    logic [CB:0]   gain;
    logic          open;
  } gated_frame_t;

  // Gated frames predicted but not yet seen on the result channel.
  gated_frame_t frames_pending[$];

  // Our own copy of the configuration registers.
  logic [CB-1:0]        attack_q;
  logic [CB-1:0]        release_q;
  logic [SB-1:0]        open_thr;
  logic [SB-1:0]        close_thr;
  logic [HOLD_BITS-1:0] hold_len;
  logic [CB:0]          floor_q;
  logic [1:0]           det_src;
  logic                 stereo_on;

  // Our own copy of the gate state.
  longint               envelope_q;
  longint               gain_q;
  logic [HOLD_BITS-1:0] hold_left;
  logic                 gate_on;

  // Fixed-point product rounded towards minus infinity.
  function automatic longint scale_q(input longint a, input longint c);
    return (a * c) >>> CB;
  endfunction

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint clamp_sample(input longint v);
    return (v > SAMPLE_MAX) ? SAMPLE_MAX : ((v < SAMPLE_MIN) ? SAMPLE_MIN : v);
  endfunction

  // Advances the gate by one frame and returns the gated frame it gives.
  function automatic gated_frame_t gate_frame(input logic [IN_W-1:0] word);
    logic signed [SB-1:0] raw_l, raw_r, raw_sl, raw_sr;
    longint               l, r, sl, sr, det, target, step_coef;
    gated_frame_t         f;
    raw_l  = word[SB-1:0];
    raw_r  = word[2*SB-1:SB];
    raw_sl = word[3*SB-1:2*SB];
    raw_sr = word[4*SB-1:3*SB];
    l  = raw_l;
    r  = raw_r;
    sl = raw_sl;
    sr = raw_sr;

    // Peak detector; the spare source code falls back to the main channels.
    case (det_src)
      DET_SIDE_L:  det = magnitude(sl);
      DET_SIDE_LR: det = (magnitude(sr) > magnitude(sl)) ? magnitude(sr) : magnitude(sl);
      default: begin
        det = magnitude(l);
        if (stereo_on && magnitude(r) > det) det = magnitude(r);
      end
    endcase

    // Envelope follower: attack while rising, release otherwise.
    step_coef  = (det > envelope_q) ? longint'(attack_q) : longint'(release_q);
    envelope_q = envelope_q + scale_q(det - envelope_q, step_coef);

    // Open at the upper level, hold, then close at the lower level.
    if (envelope_q >= longint'(open_thr)) begin
      gate_on   = 1'b1;
      hold_left = hold_len;
    end else if (gate_on && hold_left != '0) begin
      hold_left = hold_left - 1'b1;
    end else if (envelope_q <= longint'(close_thr)) begin
      gate_on = 1'b0;
    end

    // Gain glides towards unity or the floor, which is limited to unity.
    if (gate_on) begin
      target    = UNITY;
      step_coef = longint'(attack_q);
    end else begin
      target    = (longint'(floor_q) > UNITY) ? UNITY : longint'(floor_q);
      step_coef = longint'(release_q);
    end
    gain_q = gain_q + scale_q(target - gain_q, step_coef);
    if (gain_q < 0) gain_q = 0;
    if (gain_q > UNITY) gain_q = UNITY;

    f.left  = SB'(clamp_sample(scale_q(l, gain_q)));
    f.right = stereo_on ? SB'(clamp_sample(scale_q(r, gain_q))) : '0;
    f.gain  = (CB+1)'(gain_q);
    f.open  = gate_on;
    return f;
  endfunction

  task automatic note_mismatch(input string field, input longint want, input longint got);
    if (mismatches < 10) begin
      $display("Mismatch on result %0d, %s: expected %0d, got %0d",
               frames_checked, field, want, got);
    end
    mismatches++;
  endtask

  // Watch all three channels; results are compared before the new frame is queued.
  always @(posedge clk) begin : watch
    gated_frame_t  want;
    logic [SB-1:0] got_l, got_r;
    logic [CB:0]   got_g;
    logic          got_o;
    if (!rst_n) begin
      attack_q       = CB'(RST_ATTACK_COEF);
      release_q      = CB'(RST_RELEASE_COEF);
      open_thr       = SB'(RST_OPEN_LEVEL);
      close_thr      = SB'(RST_CLOSE_LEVEL);
      hold_len       = HOLD_BITS'(RST_HOLD_SAMPLES);
      floor_q        = (CB+1)'(RST_FLOOR_GAIN);
      det_src        = 2'(RST_DET_SOURCE);
      stereo_on      = 1'(RST_STEREO);
      envelope_q     = 0;
      gain_q         = 0;
      hold_left      = '0;
      gate_on        = 1'b0;
      mismatches     = 0;
      frames_checked = 0;
      frames_pending.delete();
      frames_due <= 0;
    end else begin
      // Register write transfer.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ATTACK_COEF:  attack_q  = cfg_data[CB-1:0];
          CFG_RELEASE_COEF: release_q = cfg_data[CB-1:0];
          CFG_OPEN_LEVEL:   open_thr  = cfg_data[SB-1:0];
          CFG_CLOSE_LEVEL:  close_thr = cfg_data[SB-1:0];
          CFG_HOLD_SAMPLES: hold_len  = cfg_data[HOLD_BITS-1:0];
          CFG_FLOOR_GAIN:   floor_q   = cfg_data[CB:0];
          CFG_DET_SOURCE:   det_src   = cfg_data[1:0];
          CFG_STEREO:       stereo_on = cfg_data[0];
          default: ;
        endcase
      end

      // Result transfer: compare each field with the oldest prediction.
      if (out_tvalid && out_tready) begin
        got_l = out_tdata[SB-1:0];
        got_r = out_tdata[2*SB-1:SB];
        got_g = out_tdata[2*SB+CB:2*SB];
        got_o = out_tdata[2*SB+CB+1];
        if (frames_pending.size() == 0) begin
          if (mismatches < 10) $display("Result with no frame awaiting it: %h", out_tdata);
          mismatches++;
        end else begin
          want = frames_pending.pop_front();
          if (got_l !== want.left)
            note_mismatch("out_left", $signed(want.left), $signed(got_l));
          if (got_r !== want.right)
            note_mismatch("out_right", $signed(want.right), $signed(got_r));
          if (got_g !== want.gain) note_mismatch("gain_now", want.gain, got_g);
          if (got_o !== want.open) note_mismatch("gate_open", want.open, got_o);
        end
        frames_checked++;
      end

      // Frame transfer.
      if (in_tvalid && in_tready) frames_pending.push_back(gate_frame(in_tdata));

      frames_due <= frames_pending.size();
    end
  end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import ngh_pkg::*;

  localparam int SB     = SAMPLE_BITS_DEF;
  localparam int CB     = COEF_BITS_DEF;
  localparam int IN_W   = ((4 * SB + 7) / 8) * 8;
  localparam int OUT_W  = ((2 * SB + CB + 2 + 7) / 8) * 8;
  localparam int CFG_DW = (SB > CB + 1) ? ((SB > HOLD_BITS) ? SB : HOLD_BITS) :
                                          ((CB + 1 > HOLD_BITS) ? CB + 1 : HOLD_BITS);

  localparam int HALF_PERIOD      = 10;
  localparam int RESET_CYCLES     = 8;
  localparam int CYCLE_LIMIT      = 800000;
  localparam int RANDOM_PHASES    = 10;
  localparam int FRAMES_PER_PHASE = 95;
  localparam int PRESSURE_PHASE   = 4;
  localparam int HOLD_OFF_CYCLES  = 400;
  localparam int SETTLE_CYCLES    = 12;

  localparam logic [1:0] DET_MAIN  = 2'd0;
  localparam logic [1:0] DET_SPARE = 2'd3;

  localparam int MAX_LEVEL  = 1 << (SB - 1);
  localparam int COEF_MAX   = (1 << CB) - 1;
  localparam int UNITY_GAIN = 1 << CB;
  localparam int FLOOR_MAX  = (1 << (CB + 1)) - 1;
  localparam int HOLD_MAX   = (1 << HOLD_BITS) - 1;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_W-1:0]  out_tdata;
  logic              cfg_valid;
  logic              cfg_ready;
  cfg_idx_t          cfg_index;
  logic [CFG_DW-1:0] cfg_data;

  int   mismatches;
  int   frames_due;
  int   frames_checked;
  int   cycle_count     = 0;
  int   frames_sent     = 0;
  int   settings_loaded = 0;
  int   cur_open        = RST_OPEN_LEVEL;
  int   cur_close       = RST_CLOSE_LEVEL;
  logic calm            = 1'b0;
  logic sink_hold       = 1'b0;
  bit   pressure_go     = 1'b0;

  noise_gate_hysteresis_hold dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  ngh_gate_checker #(
    .IN_W   (IN_W),
    .OUT_W  (OUT_W),
    .CFG_DW (CFG_DW)
  ) gate_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .frames_due     (frames_due),
    .frames_checked (frames_checked)
  );

  always #HALF_PERIOD clk = ~clk;

  // Cycle count and the run's time limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d frames still awaited.", frames_due);
      $display("** noise_gate_hysteresis_hold: FAILED **");
      $finish;
    end
  end

  // Now and then switch to a stretch with no idling on either side.
  always @(posedge clk) begin
    if (cycle_count % 400 == 0) calm <= ($urandom_range(0, 3) == 0);
  end

  // Idle length: mostly none or short, occasionally long.
  function automatic int pick_idle();
    int r;
    if (calm || sink_hold) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  function automatic int pick_coef();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return COEF_MAX;
    if (r < 4) return $urandom_range(1, 64);
    if (r < 7) return $urandom_range(256, 8192);
    return $urandom_range(0, COEF_MAX);
  endfunction

  function automatic int pick_level();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return MAX_LEVEL;
    return $urandom_range(0, 1 << $urandom_range(8, SB - 1));
  endfunction

  function automatic int pick_hold();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return HOLD_MAX;
    if (r == 2) return $urandom_range(0, HOLD_MAX);
    return $urandom_range(1, 40);
  endfunction

  function automatic int pick_floor();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return UNITY_GAIN;
    if (r == 2) return $urandom_range(UNITY_GAIN + 1, FLOOR_MAX);
    return $urandom_range(0, UNITY_GAIN);
  endfunction

  // Signal level for a run of frames, placed around the gate thresholds.
  function automatic int pick_amp();
    int r;
    r = $urandom_range(0, 5);
    case (r)
      0:       return (2 * cur_open + 16 > MAX_LEVEL) ? MAX_LEVEL : 2 * cur_open + 16;
      1:       return cur_close / 2;
      2:       return (cur_open + cur_close) / 2;
      3:       return MAX_LEVEL;
      4:       return 64;
      default: return (cur_open + 1 > MAX_LEVEL) ? MAX_LEVEL : cur_open + 1;
    endcase
  endfunction

  // Random sample up to the given magnitude; a few are raw random words.
  function automatic logic [SB-1:0] pick_sample(input int amp);
    int unsigned   m;
    logic [SB-1:0] v;
    if ($urandom_range(0, 19) == 0) return SB'($urandom());
    m = $urandom_range(0, amp);
    v = m[SB-1:0];
    if ($urandom_range(0, 1) == 1) v = -v;
    else if (m >= MAX_LEVEL) v = SB'(MAX_LEVEL - 1);
    return v;
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input int val);
    logic taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DW'(val);
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic load_settings(input int atk, input int rel, input int opn, input int cls,
                               input int hold, input int flr, input int src, input int st);
    write_reg(CFG_ATTACK_COEF, atk);
    write_reg(CFG_RELEASE_COEF, rel);
    write_reg(CFG_OPEN_LEVEL, opn);
    write_reg(CFG_CLOSE_LEVEL, cls);
    write_reg(CFG_HOLD_SAMPLES, hold);
    write_reg(CFG_FLOOR_GAIN, flr);
    write_reg(CFG_DET_SOURCE, src);
    write_reg(CFG_STEREO, st);
    cfg_valid <= 1'b0;
    cur_open  = opn;
    cur_close = cls;
    settings_loaded++;
  endtask

  // Offer one frame, wait for its transfer, then perhaps idle with junk on the bus.
  task automatic send_frame(input logic [SB-1:0] l, input logic [SB-1:0] r,
                            input logic [SB-1:0] sl, input logic [SB-1:0] sr);
    logic taken;
    int   gap;
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'({sr, sl, r, l});
    do begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end while (!taken);
    frames_sent++;
    gap = pick_idle();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= IN_W'({$urandom(), $urandom(), $urandom()});
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait until every predicted result has arrived and the block has settled.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (frames_due != 0);
    @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver with random stalls, held off entirely during the pressure stretch.
  initial begin : sink
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold) begin
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_idle();
      end
    end
  end

  // Long receiver hold-off so that the block fills up and stalls its input.
  initial begin : pressure
    wait (pressure_go);
    @(posedge clk);
    sink_hold <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    sink_hold <= 1'b0;
  end

  initial begin : stimulus
    int amp_main, amp_side, run, sent_in_phase, opn, cls;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_ATTACK_COEF;
    cfg_data  = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Register defaults: silence, full scale and the most negative sample.
    send_frame(24'h000000, 24'h000000, 24'h000000, 24'h000000);
    send_frame(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000);
    send_frame(24'h800000, 24'h800000, 24'h800000, 24'h800000);
    send_frame(24'hFFFFFF, 24'h000001, 24'h000000, 24'hFFFFFF);
    drain();

    // Fast follower: open, hold count-down, hysteresis band, close, reopen.
    load_settings(COEF_MAX, COEF_MAX, 100000, 50000, 2, 0, DET_MAIN, 1);
    send_frame(24'd200000, -24'd200000, 24'h000000, 24'h000000);
    send_frame(24'd75000, 24'd0, 24'h000000, 24'h000000);
    send_frame(24'd75000, 24'd0, 24'h000000, 24'h000000);
    send_frame(-24'd75000, 24'd0, 24'h000000, 24'h000000);
    send_frame(24'd20000, 24'd0, 24'h000000, 24'h000000);
    send_frame(24'd150000, 24'd0, 24'h000000, 24'h000000);
    send_frame(24'd0, 24'd0, 24'h000000, 24'h000000);
    send_frame(24'd0, 24'h800000, 24'h000000, 24'h000000);
    drain();

    // Sidechain left, mono, floor gain above unity.
    load_settings(COEF_MAX, 4096, 100000, 50000, 2, FLOOR_MAX, DET_SIDE_L, 0);
    send_frame(24'd100, 24'h7FFFFF, 24'd300000, 24'h000000);
    send_frame(24'h800000, 24'h800000, 24'h000000, 24'h7FFFFF);
    send_frame(24'h7FFFFF, 24'h123456, 24'h800000, 24'h000000);
    send_frame(24'h000000, 24'h000000, 24'h000000, 24'h000000);
    drain();

    // Both sidechain channels, floor slightly above unity, no hold.
    load_settings(8192, 8192, 100000, 50000, 0, UNITY_GAIN + 4464, DET_SIDE_LR, 1);
    send_frame(24'h7FFFFF, 24'h800000, 24'h000000, 24'h400000);
    send_frame(24'h000100, 24'hFFFF00, 24'hFFF000, 24'h000100);
    send_frame(24'h123456, 24'hFEDCBA, 24'h000000, 24'h000000);
    send_frame(24'h800000, 24'h800000, 24'h800000, 24'h800000);
    drain();

    // Spare detector code acts as the main channels; mono ignores the right one.
    load_settings(COEF_MAX, 300, 200000, 100000, 1, COEF_MAX, DET_SPARE, 0);
    send_frame(24'd300000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    send_frame(24'h000000, 24'h7FFFFF, 24'h000000, 24'h000000);
    send_frame(24'h800000, 24'h000000, 24'h000000, 24'h000000);
    send_frame(24'h000001, 24'hFFFFFF, 24'h000001, 24'hFFFFFF);

    // Random phases: runs of frames at levels around the thresholds.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain();
      if (phase == 0) begin
        load_settings(COEF_MAX, COEF_MAX, MAX_LEVEL, MAX_LEVEL, HOLD_MAX, FLOOR_MAX,
                      DET_SPARE, 1);
      end else if (phase == 1) begin
        load_settings(0, 0, 0, 0, 0, 0, DET_MAIN, 0);
      end else begin
        opn = pick_level();
        cls = ($urandom_range(0, 4) == 0) ? pick_level() : $urandom_range(0, opn);
        load_settings(pick_coef(), pick_coef(), opn, cls, pick_hold(), pick_floor(),
                      $urandom_range(0, 3), $urandom_range(0, 1));
      end
      if (phase == PRESSURE_PHASE) pressure_go = 1'b1;
      sent_in_phase = 0;
      while (sent_in_phase < FRAMES_PER_PHASE) begin
        amp_main = pick_amp();
        amp_side = ($urandom_range(0, 2) == 0) ? pick_amp() : amp_main;
        run      = $urandom_range(3, 30);
        for (int k = 0; k < run && sent_in_phase < FRAMES_PER_PHASE; k++) begin
          send_frame(pick_sample(amp_main), pick_sample(amp_main),
                     pick_sample(amp_side), pick_sample(amp_side));
          sent_in_phase++;
        end
      end
    end
    drain();

    $display("Sent %0d frames under %0d register settings and compared %0d results.",
             frames_sent, settings_loaded, frames_checked);
    $display("Both sides idled at random; the receiver held off once for %0d cycles.",
             HOLD_OFF_CYCLES);
    if (mismatches == 0) begin
      $display("** noise_gate_hysteresis_hold: PASSED **");
    end else begin
      $display("%0d mismatches found.", mismatches);
      $display("** noise_gate_hysteresis_hold: FAILED **");
    end
    $finish;
  end

endmodule
